>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers for the slot allocator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define RCSA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define RCSA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	`RCSA_ASSERT(lbl, clk, rstn, !(expr), msg)

`else

`define RCSA_ASSERT(lbl, clk, rstn, prop, msg)
`define RCSA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> src/rcsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsa_pkg
// field widths, operation and status codes and the result type of the
// reference counted slot allocator
// ----------------------------------------------------------------------------
package rcsa_pkg;

	// fixed field widths of the transfer payloads
	localparam int MODE_W      = 2;
	localparam int SLOT_W      = 9;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 16;

	// default sizing
	localparam int SLOTS_DEF      = 512;
	localparam int COUNT_BITS_DEF = 16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEC   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_OVFL = 2'd3;

	// one result item
	typedef struct packed {
		logic [SLOT_W-1:0]      slot_out;
		logic [STATUS_W-1:0]    status;
		logic                   freed;
		logic [COUNT_OUT_W-1:0] count_out;
	} rsp_t;

endpackage
`default_nettype wire

>>> src/rcsa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsa_req_if
// request channel: operation code and slot index with valid/ready
// ----------------------------------------------------------------------------
interface rcsa_req_if;
	logic                        valid;
	logic                        ready;
	logic [rcsa_pkg::MODE_W-1:0] mode;
	logic [rcsa_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output mode, output slot, input ready);
	modport sink (input valid, input mode, input slot, output ready);
endinterface
`default_nettype wire

>>> src/rcsa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsa_rsp_if
// response channel: slot, status, release flag and count with valid/ready
// ----------------------------------------------------------------------------
interface rcsa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [rcsa_pkg::SLOT_W-1:0]      slot_out;
	logic [rcsa_pkg::STATUS_W-1:0]    status;
	logic                             freed;
	logic [rcsa_pkg::COUNT_OUT_W-1:0] count_out;

	modport source (output valid, output slot_out, output status, output freed,
		output count_out, input ready);
	modport sink (input valid, input slot_out, input status, input freed,
		input count_out, output ready);
endinterface
`default_nettype wire

>>> src/refcount_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// refcount_slot_allocator_unit
// path: an accepted request registers into stage 1 with its table read, then into the result register
// throughput: one request per cycle while the response side does not stall, set by the single read port of the table
// reset: free list, watermark and handshake state clear; table not swept,
// a watermark supplies the reset contents of never written slots
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module refcount_slot_allocator_unit #(
	parameter int SLOTS      = rcsa_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rcsa_pkg::COUNT_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rcsa_req_if.sink   req,
	rcsa_rsp_if.source rsp
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int WM_W   = $clog2(SLOTS + 1);
	localparam int WORD_W = (COUNT_BITS > IDX_W) ? COUNT_BITS : IDX_W;
	localparam int MEM_W  = WORD_W + 1;

	// stage 1 and state registers
	logic                        vld_s1;
	logic [rcsa_pkg::MODE_W-1:0] mode_s1;
	logic [rcsa_pkg::SLOT_W-1:0] slot_s1;
	logic [IDX_W-1:0]            addr_s1;
	logic                        fwd_s1;
	logic [MEM_W-1:0]            fwd_data_s1;
	logic [IDX_W-1:0]            head_q;
	logic                        empty_q;
	logic [WM_W-1:0]             wm_q;
	logic                        out_vld_q;
	rcsa_pkg::rsp_t              out_q;

	// exec outputs
	rcsa_pkg::rsp_t   res;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [MEM_W-1:0] wr_data;
	logic [IDX_W-1:0] head_d;
	logic             empty_d;
	logic [WM_W-1:0]  wm_d;

	logic             adv;
	logic             acc;
	logic             we;
	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] rd_addr;
	logic [MEM_W-1:0] rd_data;

	// handshake
	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign acc       = req.valid && req.ready;
	assign we        = adv && wr_en;

	// read address: allocate reads the head left by the item now finishing
	assign head_nxt = adv ? head_d : head_q;
	assign rd_addr  = (req.mode == rcsa_pkg::MODE_ALLOC) ? head_nxt : IDX_W'(req.slot);

	rcsa_slot_ram #(
		.DEPTH  (SLOTS),
		.DATA_W (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (acc),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rcsa_exec #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_exec (
		.mode     (mode_s1),
		.slot     (slot_s1),
		.rd_addr  (addr_s1),
		.rd_data  (rd_data),
		.fwd_en   (fwd_s1),
		.fwd_data (fwd_data_s1),
		.head_q   (head_q),
		.empty_q  (empty_q),
		.wm_q     (wm_q),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.head_d   (head_d),
		.empty_d  (empty_d),
		.wm_d     (wm_d)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage 1 payload, with bypass of a write landing on the address just read
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1     <= req.mode;
			slot_s1     <= req.slot;
			addr_s1     <= rd_addr;
			fwd_s1      <= we && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// free list head, empty flag and write watermark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= IDX_W'(1);
			empty_q <= 1'b0;
			wm_q    <= WM_W'(1);
		end else if (adv) begin
			head_q  <= head_d;
			empty_q <= empty_d;
			wm_q    <= wm_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.slot_out  = out_q.slot_out;
	assign rsp.status    = out_q.status;
	assign rsp.freed     = out_q.freed;
	assign rsp.count_out = out_q.count_out;

	// checks
	`RCSA_ASSERT_NEVER(a_head_not_reserved, clk, arst_n, head_q == '0, "free head is slot 0")
	`RCSA_ASSERT(a_wm_bounds, clk, arst_n, (wm_q != '0) && (wm_q <= WM_W'(SLOTS)), "watermark out of range")
	`RCSA_ASSERT(a_release_head, clk, arst_n, adv && res.freed |=> !empty_q && (head_q == $past(addr_s1)), "released slot not at head")
	`RCSA_ASSERT(a_alloc_marks_used, clk, arst_n, adv && (mode_s1 == rcsa_pkg::MODE_ALLOC) && (res.status == rcsa_pkg::STATUS_OK) |-> we && wr_data[MEM_W-1], "allocate without in-use write")
	`RCSA_ASSERT(a_stall_holds, clk, arst_n, vld_s1 && !adv |=> vld_s1 && $stable(addr_s1), "stage 1 lost while stalled")

endmodule
`default_nettype wire

>>> src/rcsa_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsa_slot_ram
// one write port, one read port slot table with registered read data
// ----------------------------------------------------------------------------
module rcsa_slot_ram #(
	parameter int DEPTH  = rcsa_pkg::SLOTS_DEF,
	parameter int DATA_W = rcsa_pkg::COUNT_BITS_DEF + 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/rcsa_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsa_exec
// single pass operation logic: decodes the slot word, builds the result,
// the table write and the next free list state
// ----------------------------------------------------------------------------
module rcsa_exec #(
	parameter int SLOTS      = rcsa_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rcsa_pkg::COUNT_BITS_DEF
) (
	input  wire logic [rcsa_pkg::MODE_W-1:0] mode,
	input  wire logic [rcsa_pkg::SLOT_W-1:0] slot,
	input  wire logic [$clog2(SLOTS)-1:0]    rd_addr,
	input  wire logic [((COUNT_BITS > $clog2(SLOTS)) ? COUNT_BITS : $clog2(SLOTS)):0] rd_data,
	input  wire logic                        fwd_en,
	input  wire logic [((COUNT_BITS > $clog2(SLOTS)) ? COUNT_BITS : $clog2(SLOTS)):0] fwd_data,
	input  wire logic [$clog2(SLOTS)-1:0]    head_q,
	input  wire logic                        empty_q,
	input  wire logic [$clog2(SLOTS+1)-1:0]  wm_q,
	output rcsa_pkg::rsp_t                   res,
	output logic                             wr_en,
	output logic      [$clog2(SLOTS)-1:0]    wr_addr,
	output logic      [((COUNT_BITS > $clog2(SLOTS)) ? COUNT_BITS : $clog2(SLOTS)):0] wr_data,
	output logic      [$clog2(SLOTS)-1:0]    head_d,
	output logic                             empty_d,
	output logic      [$clog2(SLOTS+1)-1:0]  wm_d
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int WM_W   = $clog2(SLOTS + 1);
	localparam int WORD_W = (COUNT_BITS > IDX_W) ? COUNT_BITS : IDX_W;
	localparam int MEM_W  = WORD_W + 1;

	logic                  untouched;
	logic [MEM_W-1:0]      entry;
	logic                  in_use;
	logic [WORD_W-1:0]     word;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic                  cnt_max;
	logic                  cnt_zero;
	logic                  cnt_one;
	logic                  slot_ok;
	logic                  link_last;
	logic [IDX_W-1:0]      link_idx;

	// entries at or above the watermark were never written and are read as the
	// reset chain i -> i+1 with the in-use bit clear
	assign untouched = WM_W'(rd_addr) >= wm_q;
	assign entry     = fwd_en ? fwd_data : (untouched ? '0 : rd_data);
	assign in_use    = entry[MEM_W-1];
	assign word      = entry[WORD_W-1:0];
	assign cnt       = word[COUNT_BITS-1:0];
	assign cnt_inc   = cnt + COUNT_BITS'(1);
	assign cnt_dec   = cnt - COUNT_BITS'(1);
	assign cnt_max   = cnt == '1;
	assign cnt_zero  = cnt == '0;
	assign cnt_one   = cnt == COUNT_BITS'(1);

	// slot must be in range, not the reserved slot and in use
	assign slot_ok = (32'(slot) < 32'(SLOTS)) && (slot != '0) && in_use;

	// link of the free list head
	always_comb begin
		if (untouched && !fwd_en) begin
			link_last = rd_addr == IDX_W'(SLOTS - 1);
			link_idx  = rd_addr + IDX_W'(1);
		end else begin
			link_last = ({1'b0, word} >= (WORD_W + 1)'(SLOTS)) || (word == WORD_W'(rd_addr));
			link_idx  = word[IDX_W-1:0];
		end
	end

	// operation decode
	always_comb begin
		res.slot_out  = slot;
		res.status    = rcsa_pkg::STATUS_OK;
		res.freed     = 1'b0;
		res.count_out = '0;
		wr_en         = 1'b0;
		wr_addr       = rd_addr;
		wr_data       = '0;
		head_d        = head_q;
		empty_d       = empty_q;
		wm_d          = wm_q;
		case (mode)
			rcsa_pkg::MODE_ALLOC: begin
				if (empty_q) begin
					res.slot_out = '0;
					res.status   = rcsa_pkg::STATUS_FULL;
				end else begin
					res.slot_out = rcsa_pkg::SLOT_W'(rd_addr);
					wr_en        = 1'b1;
					wr_data      = {1'b1, WORD_W'(0)};
					if (link_last) begin
						empty_d = 1'b1;
					end else begin
						head_d = link_idx;
					end
					if (untouched && !fwd_en) begin
						wm_d = wm_q + WM_W'(1);
					end
				end
			end
			rcsa_pkg::MODE_INC: begin
				if (!slot_ok) begin
					res.status = rcsa_pkg::STATUS_BAD;
				end else if (cnt_max) begin
					res.status    = rcsa_pkg::STATUS_OVFL;
					res.count_out = rcsa_pkg::COUNT_OUT_W'(cnt);
				end else begin
					wr_en         = 1'b1;
					wr_data       = {1'b1, WORD_W'(cnt_inc)};
					res.count_out = rcsa_pkg::COUNT_OUT_W'(cnt_inc);
				end
			end
			rcsa_pkg::MODE_DEC: begin
				if (!slot_ok || cnt_zero) begin
					res.status = rcsa_pkg::STATUS_BAD;
				end else if (cnt_one) begin
					// release: push the slot onto the free list
					wr_en     = 1'b1;
					wr_data   = {1'b0, WORD_W'(empty_q ? rd_addr : head_q)};
					head_d    = rd_addr;
					empty_d   = 1'b0;
					res.freed = 1'b1;
				end else begin
					wr_en         = 1'b1;
					wr_data       = {1'b1, WORD_W'(cnt_dec)};
					res.count_out = rcsa_pkg::COUNT_OUT_W'(cnt_dec);
				end
			end
			default: begin
				res.count_out = slot_ok ? rcsa_pkg::COUNT_OUT_W'(cnt) : '0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the reference counted slot allocator against a behavioral copy of
// its slot table: directed corner requests, a back to back increment run, a
// fill to the full table, then random traffic shaped around live slots
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned NSLOTS         = rcsa_pkg::SLOTS_DEF;
	localparam int unsigned COUNT_MAX      = (1 << rcsa_pkg::COUNT_BITS_DEF) - 1;
	localparam int unsigned HOLD_CYCLES    = 150;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned EPOCHS         = 13;
	localparam int unsigned EPOCH_ITEMS    = 100;
	localparam int unsigned INC_RUN        = 40;

	// behavioral slot table and the replies it predicts
	class refcount_tracker;
		logic [rcsa_pkg::COUNT_BITS_DEF-1:0] word [NSLOTS];
		bit                                  in_use [NSLOTS];
		int unsigned                         head;
		bit                                  list_empty;
		rcsa_pkg::rsp_t                      predicted_replies [$];
		int unsigned                         errors;
		int unsigned                         requests;
		int unsigned                         replies;
		int unsigned                         full_hits;
		int unsigned                         rejects;
		int unsigned                         saturations;
		int unsigned                         releases;

		function new();
			int unsigned i;
			for (i = 0; i < NSLOTS; i++) begin
				word[i] = rcsa_pkg::COUNT_BITS_DEF'(i + 1);
				in_use[i] = 1'b0;
			end
			head = 1;
			list_empty = 1'b0;
		endfunction

		function int unsigned pending();
			return predicted_replies.size();
		endfunction

		task log_mismatch(string what, int unsigned got, int unsigned want);
			errors++;
			$display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got,
				want);
		endtask

		// apply one accepted request to the table and queue its reply
		task take_request(logic [rcsa_pkg::MODE_W-1:0] mode,
				logic [rcsa_pkg::SLOT_W-1:0] slot);
			rcsa_pkg::rsp_t r;
			int unsigned    w;
			int unsigned    link;
			bit             live;
			r = '0;
			r.slot_out = slot;
			live = (slot != 0) && in_use[slot];
			requests++;
			if (mode == rcsa_pkg::MODE_ALLOC) begin
				// pop the free list head
				r.slot_out = '0;
				if (list_empty || head >= NSLOTS) begin
					r.status = rcsa_pkg::STATUS_FULL;
				end else begin
					w = head;
					link = word[w];
					if (link >= NSLOTS || link == w)
						list_empty = 1'b1;
					else
						head = link;
					word[w] = '0;
					in_use[w] = 1'b1;
					r.slot_out = w[rcsa_pkg::SLOT_W-1:0];
				end
			end else if (mode == rcsa_pkg::MODE_PEEK) begin
				if (live)
					r.count_out = word[slot];
			end else if (!live) begin
				r.status = rcsa_pkg::STATUS_BAD;
			end else if (mode == rcsa_pkg::MODE_INC) begin
				// count sticks at its maximum
				if (word[slot] >= COUNT_MAX) begin
					r.status = rcsa_pkg::STATUS_OVFL;
				end else begin
					word[slot] = word[slot] + 1'b1;
				end
				r.count_out = word[slot];
			end else if (word[slot] == 0) begin
				r.status = rcsa_pkg::STATUS_BAD;
			end else begin
				// decrement, release on reaching zero
				word[slot] = word[slot] - 1'b1;
				if (word[slot] == 0) begin
					word[slot] = list_empty ? rcsa_pkg::COUNT_BITS_DEF'(slot) :
						rcsa_pkg::COUNT_BITS_DEF'(head);
					head = slot;
					list_empty = 1'b0;
					in_use[slot] = 1'b0;
					r.freed = 1'b1;
				end else begin
					r.count_out = word[slot];
				end
			end
			if (r.status == rcsa_pkg::STATUS_FULL) full_hits++;
			if (r.status == rcsa_pkg::STATUS_BAD) rejects++;
			if (r.status == rcsa_pkg::STATUS_OVFL) saturations++;
			if (r.freed) releases++;
			predicted_replies.push_back(r);
		endtask

		// compare one accepted reply with the oldest prediction
		task match_reply(rcsa_pkg::rsp_t got);
			rcsa_pkg::rsp_t want;
			replies++;
			if (predicted_replies.size() == 0) begin
				log_mismatch("reply with nothing outstanding", got.slot_out, 0);
			end else begin
				want = predicted_replies.pop_front();
				if (got.slot_out !== want.slot_out)
					log_mismatch("slot_out", got.slot_out, want.slot_out);
				if (got.status !== want.status)
					log_mismatch("status", got.status, want.status);
				if (got.freed !== want.freed)
					log_mismatch("freed", got.freed, want.freed);
				if (got.count_out !== want.count_out)
					log_mismatch("count_out", got.count_out, want.count_out);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   hold_rsp;
	int unsigned stuck_cycles;

	refcount_tracker tracker = new();

	rcsa_req_if req_ch ();
	rcsa_rsp_if rsp_ch ();

	refcount_slot_allocator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// transfer monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				tracker.take_request(req_ch.mode, req_ch.slot);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				tracker.match_reply({rsp_ch.slot_out, rsp_ch.status, rsp_ch.freed,
					rsp_ch.count_out});
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", stuck_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// reply side: random stalls, one long hold on request
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = steady ? 0 : $urandom_range(0, 4);
				if (gap != 0) begin
					rsp_ch.ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// offer one request and return at the falling edge after its transfer
	task automatic send_req(logic [rcsa_pkg::MODE_W-1:0] mode,
			logic [rcsa_pkg::SLOT_W-1:0] slot);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode = mode;
		req_ch.slot = slot;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// stop offering until every predicted reply is back
	task automatic wait_all_replies();
		req_ch.valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	// a slot in use, preferring one with a nonzero count when asked
	function automatic logic [rcsa_pkg::SLOT_W-1:0] pick_live(bit want_count);
		int unsigned s;
		int unsigned n;
		s = $urandom_range(1, NSLOTS - 1);
		for (n = 0; n < 2 * (NSLOTS - 1); n++) begin
			if (tracker.in_use[s] && (!want_count || n >= NSLOTS - 1 || tracker.word[s] != 0))
				return s[rcsa_pkg::SLOT_W-1:0];
			s = (s == NSLOTS - 1) ? 1 : s + 1;
		end
		return s[rcsa_pkg::SLOT_W-1:0];
	endfunction

	// allocations, operations on live slots and random noise, mixed by the given percentages
	task automatic random_epoch(int unsigned alloc_pct, int unsigned dec_pct);
		int unsigned r;
		int unsigned k;
		int unsigned i;
		for (i = 0; i < EPOCH_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
			end else if (r < 88) begin
				k = $urandom_range(0, 99);
				if (k < dec_pct)
					send_req(rcsa_pkg::MODE_DEC, pick_live(1'b1));
				else if (k < 92)
					send_req(rcsa_pkg::MODE_INC, pick_live(1'b0));
				else
					send_req(rcsa_pkg::MODE_PEEK, pick_live(1'b0));
			end else begin
				send_req(rcsa_pkg::MODE_W'($urandom_range(0, 3)),
					rcsa_pkg::SLOT_W'($urandom_range(0, NSLOTS - 1)));
			end
		end
	endtask

	// stimulus
	initial begin
		logic [rcsa_pkg::SLOT_W-1:0] victim;
		int unsigned                 e;
		arst_n = 1'b0;
		steady = 1'b0;
		hold_rsp = 1'b0;
		stuck_cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.mode = rcsa_pkg::MODE_ALLOC;
		req_ch.slot = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reserved slot, free slots, underflow, release onto a nonempty list
		send_req(rcsa_pkg::MODE_PEEK, 9'd0);
		send_req(rcsa_pkg::MODE_INC, 9'd0);
		send_req(rcsa_pkg::MODE_DEC, 9'd0);
		send_req(rcsa_pkg::MODE_DEC, 9'h1FF);
		send_req(rcsa_pkg::MODE_INC, 9'd300);
		send_req(rcsa_pkg::MODE_ALLOC, 9'h1FF);
		send_req(rcsa_pkg::MODE_DEC, 9'd1);
		send_req(rcsa_pkg::MODE_INC, 9'd1);
		send_req(rcsa_pkg::MODE_PEEK, 9'd1);
		send_req(rcsa_pkg::MODE_ALLOC, 9'd0);
		send_req(rcsa_pkg::MODE_DEC, 9'd1);
		send_req(rcsa_pkg::MODE_ALLOC, 9'h155);
		send_req(rcsa_pkg::MODE_PEEK, 9'h1FF);
		wait_all_replies();

		// back to back increments on one slot with read-after-write hazards
		steady = 1'b1;
		repeat (INC_RUN) send_req(rcsa_pkg::MODE_INC, 9'd1);
		send_req(rcsa_pkg::MODE_INC, 9'd1);
		send_req(rcsa_pkg::MODE_PEEK, 9'd1);
		send_req(rcsa_pkg::MODE_DEC, 9'd1);
		send_req(rcsa_pkg::MODE_INC, 9'd1);
		steady = 1'b0;
		wait_all_replies();

		// fill the table, then release onto the empty list and refill
		while (!tracker.list_empty)
			send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
		send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
		send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
		victim = pick_live(1'b0);
		send_req(rcsa_pkg::MODE_INC, victim);
		send_req(rcsa_pkg::MODE_DEC, victim);
		send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
		send_req(rcsa_pkg::MODE_ALLOC, rcsa_pkg::SLOT_W'($urandom));
		wait_all_replies();

		// random epochs with shifting allocate and release pressure
		for (e = 0; e < EPOCHS; e++) begin
			steady = (e % 5 == 4) || (e == 2);
			if (e == 2)
				hold_rsp = 1'b1;
			case (e % 3)
				0: random_epoch(45, 30);
				1: random_epoch(20, 45);
				default: random_epoch(8, 60);
			endcase
			if (e % 4 == 3)
				wait_all_replies();
		end
		steady = 1'b0;

		wait_all_replies();
		repeat (8) @(negedge clk);
		$display("run covered %0d requests and %0d replies, including a table fill",
			tracker.requests, tracker.replies);
		$display("table full %0d, rejected %0d, saturated %0d, released %0d",
			tracker.full_hits, tracker.rejects, tracker.saturations, tracker.releases);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
